>>> rtl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants for the dashboard frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int BYTE_W = 8;
	localparam int SP_W   = 15;
	localparam int LEN_W  = 9;
	localparam int SUM_W  = 16;
	localparam int PROD_W = BYTE_W + SP_W;
	localparam int CNT_W  = $clog2(SP_W);

	// Frame markers and commands
	localparam logic [BYTE_W-1:0] SOF_FIRST   = 8'h55;
	localparam logic [BYTE_W-1:0] SOF_SECOND  = 8'hAA;
	localparam logic [SUM_W-1:0]  CHK_INVERT  = 16'hFFFF;
	localparam logic [BYTE_W-1:0] CMD_STATUS  = 8'h64;
	localparam logic [BYTE_W-1:0] CMD_SET     = 8'h65;
	localparam logic [LEN_W-1:0]  LEN_EXTRA   = 9'd6;

	// Frame offsets
	localparam logic [LEN_W-1:0]  OFS_BODY     = 9'd3;
	localparam logic [LEN_W-1:0]  OFS_LEN      = 9'd2;
	localparam logic [LEN_W-1:0]  OFS_COMMAND  = 9'd4;
	localparam logic [LEN_W-1:0]  OFS_THROTTLE = 9'd7;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_FULL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUR_MAX    = 2'd2;

	// Configuration reset values
	localparam logic [BYTE_W-1:0] RST_THR_OFFSET = 8'd45;
	localparam logic [BYTE_W-1:0] RST_THR_FULL   = 8'd175;
	localparam logic [SP_W-1:0]   RST_CUR_MAX    = 15'd2000;

	typedef struct packed {
		logic [BYTE_W-1:0] thr_offset;
		logic [BYTE_W-1:0] thr_full;
		logic [SP_W-1:0]   cur_max;
	} cfg_t;

	// One finished frame, handed from the parser to the setpoint unit
	typedef struct packed {
		logic              ok;
		logic [BYTE_W-1:0] command;
		logic              reply_req;
		logic              map_req;
		logic [BYTE_W-1:0] throttle;
	} frame_rec_t;

endpackage

>>> rtl/dfr_front.sv
// ----------------------------------------------------------------------------
// dfr_front
// Byte parser: hunts for the start mark, tracks the frame, sums the length and
// body and checks the trailer. Emits one frame record at the last byte.
// ----------------------------------------------------------------------------
module dfr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_en,
	input  logic [dfr_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          push,
	output dfr_pkg::frame_rec_t           rec
);
	import dfr_pkg::*;

	typedef enum logic [1:0] {ST_HUNT, ST_LEN, ST_BODY} state_t;

	state_t            state_q;
	logic [BYTE_W-1:0] prev_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  len_q;
	logic [SUM_W-1:0]  sum_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] thr_q;
	logic [BYTE_W-1:0] trl_q;

	logic              in_sum;
	logic              at_trl;
	logic              at_last;
	logic              chk_ok;
	logic [BYTE_W-1:0] thr_now;

	assign in_sum  = (idx_q + 9'd2) < len_q;
	assign at_trl  = (idx_q + 9'd2) == len_q;
	assign at_last = (idx_q + 9'd1) == len_q;
	assign chk_ok  = (sum_q ^ CHK_INVERT) == {rx_byte, trl_q};
	// the throttle byte may be the frame's last byte itself, so take it from the input
	assign thr_now = (idx_q == OFS_THROTTLE) ? rx_byte : thr_q;

	assign push = byte_en && (state_q == ST_BODY) && at_last;

	always_comb begin
		rec.ok        = chk_ok;
		rec.command   = cmd_q;
		rec.reply_req = chk_ok && (cmd_q == CMD_STATUS);
		rec.map_req   = chk_ok && ((cmd_q == CMD_STATUS) || (cmd_q == CMD_SET));
		rec.throttle  = thr_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			prev_q  <= '0;
			idx_q   <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			cmd_q   <= '0;
			thr_q   <= '0;
			trl_q   <= '0;
		end else if (byte_en) begin
			prev_q <= rx_byte;
			case (state_q)
				ST_LEN: begin
					len_q   <= {1'b0, rx_byte} + LEN_EXTRA;
					sum_q   <= SUM_W'(rx_byte);
					idx_q   <= OFS_BODY;
					state_q <= ST_BODY;
				end
				ST_BODY: begin
					if (in_sum) sum_q <= sum_q + SUM_W'(rx_byte);
					if (idx_q == OFS_COMMAND) cmd_q <= rx_byte;
					if (idx_q == OFS_THROTTLE) thr_q <= rx_byte;
					if (at_trl) trl_q <= rx_byte;
					if (at_last) state_q <= ST_HUNT;
					else idx_q <= idx_q + 9'd1;
				end
				default: begin
					if (prev_q == SOF_FIRST && rx_byte == SOF_SECOND) begin
						state_q <= ST_LEN;
						idx_q   <= OFS_LEN;
						sum_q   <= '0;
						cmd_q   <= '0;
						thr_q   <= '0;
						trl_q   <= '0;
					end else begin
						state_q <= ST_HUNT;
					end
				end
			endcase
		end
	end

endmodule

>>> rtl/dfr_queue.sv
// ----------------------------------------------------------------------------
// dfr_queue
// Two-entry queue of frame records between parser and setpoint unit.
// ----------------------------------------------------------------------------
module dfr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dfr_pkg::frame_rec_t  rec_in,
	input  logic                 pop,
	output logic                 full,
	output logic                 valid,
	output dfr_pkg::frame_rec_t  head
);
	import dfr_pkg::*;

	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int CNT_QW  = $clog2(Q_DEPTH + 1);

	frame_rec_t        mem_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_QW-1:0] cnt_q;

	assign full  = cnt_q == CNT_QW'(Q_DEPTH);
	assign valid = cnt_q != '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= rec_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_QW'(1);
				2'b01:   cnt_q <= cnt_q - CNT_QW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/dfr_back.sv
// ----------------------------------------------------------------------------
// dfr_back
// Setpoint unit: maps the throttle byte to a clamped current setpoint with one
// multiply and a bit-serial divide, and holds the result in the output register.
// ----------------------------------------------------------------------------
module dfr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dfr_pkg::cfg_t               cfg,
	input  logic                        q_valid,
	input  dfr_pkg::frame_rec_t         q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        frame_ok,
	output logic [dfr_pkg::BYTE_W-1:0]  command,
	output logic                        reply_request,
	output logic                        setpoint_valid,
	output logic [dfr_pkg::SP_W-1:0]    setpoint
);
	import dfr_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV} state_t;

	state_t            state_q;
	logic [BYTE_W-1:0] a_q;
	logic [BYTE_W-1:0] d_q;
	logic [BYTE_W-1:0] cmd_q;
	logic              rr_q;
	logic [BYTE_W-1:0] rem_q;
	logic [SP_W-1:0]   quo_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              out_valid_q;
	logic              frame_ok_q;
	logic [BYTE_W-1:0] command_q;
	logic              reply_request_q;
	logic              setpoint_valid_q;
	logic [SP_W-1:0]   setpoint_q;

	logic              take;
	logic [BYTE_W:0]   num;
	logic [BYTE_W:0]   den;
	logic [BYTE_W:0]   num_neg;
	logic [BYTE_W:0]   den_neg;
	logic [BYTE_W-1:0] abs_n;
	logic [BYTE_W-1:0] abs_d;
	logic [PROD_W-1:0] prod;
	logic [BYTE_W:0]   trial;
	logic [BYTE_W:0]   diff;
	logic              ge;
	logic [SP_W-1:0]   quo_nx;

	assign take  = (state_q == B_IDLE) && q_valid && (!out_valid_q || out_ready);
	assign q_pop = take;

	// signed throttle distance and span
	assign num     = {1'b0, q_head.throttle} - {1'b0, cfg.thr_offset};
	assign den     = {1'b0, cfg.thr_full} - {1'b0, cfg.thr_offset};
	assign num_neg = -num;
	assign den_neg = -den;
	assign abs_n   = num[BYTE_W] ? num_neg[BYTE_W-1:0] : num[BYTE_W-1:0];
	assign abs_d   = den[BYTE_W] ? den_neg[BYTE_W-1:0] : den[BYTE_W-1:0];

	assign prod = PROD_W'(a_q) * PROD_W'(cfg.cur_max);

	// one restoring divide step
	assign trial  = {rem_q, quo_q[SP_W-1]};
	assign diff   = trial - {1'b0, d_q};
	assign ge     = trial >= {1'b0, d_q};
	assign quo_nx = {quo_q[SP_W-2:0], ge};

	assign out_valid      = out_valid_q;
	assign frame_ok       = frame_ok_q;
	assign command        = command_q;
	assign reply_request  = reply_request_q;
	assign setpoint_valid = setpoint_valid_q;
	assign setpoint       = setpoint_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= B_IDLE;
			a_q              <= '0;
			d_q              <= '0;
			cmd_q            <= '0;
			rr_q             <= 1'b0;
			rem_q            <= '0;
			quo_q            <= '0;
			cnt_q            <= '0;
			out_valid_q      <= 1'b0;
			frame_ok_q       <= 1'b0;
			command_q        <= '0;
			reply_request_q  <= 1'b0;
			setpoint_valid_q <= 1'b0;
			setpoint_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (take) begin
						frame_ok_q       <= q_head.ok;
						command_q        <= q_head.command;
						reply_request_q  <= q_head.reply_req;
						setpoint_valid_q <= q_head.map_req;
						setpoint_q       <= '0;
						if (!q_head.map_req) begin
							out_valid_q <= 1'b1;
						end else if (den == '0) begin
							out_valid_q <= 1'b1;
							if (!num[BYTE_W]) setpoint_q <= cfg.cur_max;
						end else if ((num == '0) || (num[BYTE_W] != den[BYTE_W])) begin
							out_valid_q <= 1'b1;
						end else if (abs_n >= abs_d) begin
							out_valid_q <= 1'b1;
							setpoint_q  <= cfg.cur_max;
						end else begin
							a_q     <= abs_n;
							d_q     <= abs_d;
							cmd_q   <= q_head.command;
							rr_q    <= q_head.reply_req;
							state_q <= B_MUL;
						end
					end
				end
				B_MUL: begin
					// quotient fits in SP_W bits since distance < span
					rem_q   <= prod[PROD_W-1:SP_W];
					quo_q   <= prod[SP_W-1:0];
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					rem_q <= ge ? diff[BYTE_W-1:0] : trial[BYTE_W-1:0];
					quo_q <= quo_nx;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SP_W - 1)) begin
						out_valid_q      <= 1'b1;
						frame_ok_q       <= 1'b1;
						command_q        <= cmd_q;
						reply_request_q  <= rr_q;
						setpoint_valid_q <= 1'b1;
						setpoint_q       <= quo_nx;
						state_q          <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/dashboard_frame_receiver.sv
// ----------------------------------------------------------------------------
// dashboard_frame_receiver
// Serial dashboard frame parser with additive checksum and throttle mapping.
// ----------------------------------------------------------------------------
// Feed received serial bytes one beat at a time on the input channel. The
// parser hunts for 0x55 0xAA, takes the next byte as the length L (frame is
// L+6 bytes from the 0x55), sums length and body and compares the inverted low 16
// bits of the sum with the little-endian trailer. Each complete frame yields
// exactly one result beat, good or bad. A good frame with command 0x64 or 0x65
// carries a current setpoint mapped linearly from the byte at frame offset 7
// and clamped to 0..current_max; 0x64 also flags a reply request. Timing: the
// parser takes one byte per cycle. A frame's last byte pushes a record into a
// two-entry queue; a result that needs no division is registered as it leaves
// the queue, a mapped setpoint passes an issue step, a multiply step and a
// one-bit-per-cycle restoring divider before it is registered. The input
// stalls only when the queue holds two frames. Write the configuration
// registers (index 0 throttle_offset, 1 throttle_full, 2 current_max, index 3
// ignored) only while no frame is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
module dashboard_frame_receiver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dfr_pkg::BYTE_W-1:0]      rx_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            frame_ok,
	output logic [dfr_pkg::BYTE_W-1:0]      command,
	output logic                            reply_request,
	output logic                            setpoint_valid,
	output logic [dfr_pkg::SP_W-1:0]        setpoint,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dfr_pkg::SP_W-1:0]        cfg_data
);
	import dfr_pkg::*;

	cfg_t       cfg_q;
	logic       byte_en;
	logic       push;
	frame_rec_t rec;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;
	frame_rec_t q_head;

	// Configuration: accept every write beat, drop unknown indexes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_offset <= RST_THR_OFFSET;
			cfg_q.thr_full   <= RST_THR_FULL;
			cfg_q.cur_max    <= RST_CUR_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THR_OFFSET: cfg_q.thr_offset <= cfg_data[BYTE_W-1:0];
				CFG_THR_FULL:   cfg_q.thr_full   <= cfg_data[BYTE_W-1:0];
				CFG_CUR_MAX:    cfg_q.cur_max    <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Hold the byte stream only while the frame queue is full
	assign in_ready = !q_full;
	assign byte_en  = in_valid && in_ready;

	// Front: classify bytes and build one record per frame
	dfr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.rx_byte (rx_byte),
		.push    (push),
		.rec     (rec)
	);

	// Decouple the parser from the setpoint unit
	dfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.rec_in (rec),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.head   (q_head)
	);

	// Back: map throttle, clamp, and drive the result beat
	dfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_ok       (frame_ok),
		.command        (command),
		.reply_request  (reply_request),
		.setpoint_valid (setpoint_valid),
		.setpoint       (setpoint)
	);

`ifndef SYNTHESIS
	// A frame record never lands on a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("frame record pushed into full queue");

	// An applied setpoint never exceeds the current limit
	a_setpoint_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && setpoint_valid) |-> (setpoint <= cfg_q.cur_max))
		else $error("setpoint above current_max");

	// Reply needs an applied setpoint, which needs a good frame
	a_flag_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!reply_request || setpoint_valid) && (!setpoint_valid || frame_ok)))
		else $error("result flags inconsistent");

	// Setpoint stays zero when it is not applied
	a_setpoint_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !setpoint_valid) |-> (setpoint == '0))
		else $error("setpoint nonzero without setpoint_valid");
`endif

endmodule
